@@ rtl/qrot_pkg.sv @@
// qrot_pkg: widths, register indexes and payload types for the quaternion rotation core
// no dependencies
`default_nettype none

package qrot_pkg;

   localparam int COMP_W = 16;   // component and rotor width
   localparam int PROD_W = 32;   // rotor times component
   localparam int P_W    = 34;   // sum of four first-product terms
   localparam int PROD2_W = 50;  // first product times rotor
   localparam int NUM_W  = 52;   // numerator of the quotient
   localparam int SQ_W   = 32;   // one rotor square
   localparam int NORM_W = 33;   // squared rotor norm, up to 2^32
   localparam int QUO_W  = 16;   // magnitude quotient bits
   localparam int ADDR_W = 4;
   localparam int DATA_W = 32;
   localparam int DIV_LAT = 10;  // register depth of one divider lane
   localparam int LAT    = 4 + DIV_LAT;

   localparam logic [1:0] REG_ROTOR_W = 2'd0;
   localparam logic [1:0] REG_ROTOR_X = 2'd1;
   localparam logic [1:0] REG_ROTOR_Y = 2'd2;
   localparam logic [1:0] REG_ROTOR_Z = 2'd3;

   localparam logic signed [COMP_W-1:0] ROTOR_W_RESET = 16'sd16384;
   localparam logic [SQ_W-1:0]   SQ_W_RESET   = 32'd268435456;
   localparam logic [NORM_W-1:0] NORM_RESET   = 33'd268435456;

   typedef logic signed [COMP_W-1:0] comp_type;

endpackage

`default_nettype wire

@@ rtl/qrot_req_if.sv @@
// qrot_req_if: input transfer channel carrying one quaternion
// depends on qrot_pkg
`default_nettype none

interface qrot_req_if;
   import qrot_pkg::*;
   logic     valid;
   logic     ready;
   comp_type in_w;
   comp_type in_x;
   comp_type in_y;
   comp_type in_z;

   modport source (output valid, in_w, in_x, in_y, in_z, input ready);
   modport sink   (input valid, in_w, in_x, in_y, in_z, output ready);
endinterface

`default_nettype wire

@@ rtl/qrot_rsp_if.sv @@
// qrot_rsp_if: result transfer channel carrying one rotated quaternion and flags
// depends on qrot_pkg
`default_nettype none

interface qrot_rsp_if;
   import qrot_pkg::*;
   logic     valid;
   logic     ready;
   comp_type out_w;
   comp_type out_x;
   comp_type out_y;
   comp_type out_z;
   logic     clipped;
   logic     zero_rotor;

   modport source (output valid, out_w, out_x, out_y, out_z, clipped, zero_rotor,
                   input ready);
   modport sink   (input valid, out_w, out_x, out_y, out_z, clipped, zero_rotor,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/quaternion_rotation_core.sv @@
// quaternion_rotation_core: top level, rotates streamed quaternions by a programmed rotor
// depends on qrot_pkg, qrot_req_if, qrot_rsp_if and qrot_div
//
// usage
//  - req channel: one quaternion (in_w..in_z) per transfer on valid & ready
//  - rsp channel: rotated quaternion q*v*conj(q)/|q|^2, truncated toward zero,
//    saturated to 16 bits, with clipped and zero_rotor flags
//  - apb port: rotor_w/x/y/z at byte offsets 0, 4, 8, 12, signed q2.14 in
//    pwdata[15:0]; reads return the sign-extended value; pready is tied high
//  - write the rotor only while no transfer is in flight; the squared norm
//    settles through the square and sum registers after the write
//  - two multiply/sum pairs form the hamilton products, then a ten-stage
//    divider lane runs per component (two quotient bits a stage)
//  - one transfer per cycle unless rsp stalls; every stage advances together
//  - when rsp stalls with a result waiting, the whole pipe freezes and
//    req.ready drops; while the output stage is empty the pipe keeps moving
//  - reset restores the identity rotor and empties the pipe
`default_nettype none

module quaternion_rotation_core
   import qrot_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   qrot_req_if.sink               req,
   qrot_rsp_if.source             rsp,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [ADDR_W-1:0] paddr,
   input  wire logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0]      prdata,
   output logic                   pready
);

   // rotor registers
   comp_type rot_ff [4];
   logic     csr_wr;
   logic [1:0] csr_idx;

   assign pready  = 1'b1;
   assign csr_wr  = psel & penable & pwrite & pready;
   assign csr_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff[0] <= ROTOR_W_RESET;
         rot_ff[1] <= '0;
         rot_ff[2] <= '0;
         rot_ff[3] <= '0;
      end else if (csr_wr) begin
         case (csr_idx)
            REG_ROTOR_W: rot_ff[0] <= pwdata[COMP_W-1:0];
            REG_ROTOR_X: rot_ff[1] <= pwdata[COMP_W-1:0];
            REG_ROTOR_Y: rot_ff[2] <= pwdata[COMP_W-1:0];
            REG_ROTOR_Z: rot_ff[3] <= pwdata[COMP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_ROTOR_W: prdata = DATA_W'(rot_ff[0]);
         REG_ROTOR_X: prdata = DATA_W'(rot_ff[1]);
         REG_ROTOR_Y: prdata = DATA_W'(rot_ff[2]);
         REG_ROTOR_Z: prdata = DATA_W'(rot_ff[3]);
         default:     prdata = '0;
      endcase
   end

   // squared norm, two stages off the rotor registers
   logic [SQ_W-1:0]   sq_ff [4];
   logic [NORM_W-1:0] norm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff[0] <= SQ_W_RESET;
         sq_ff[1] <= '0;
         sq_ff[2] <= '0;
         sq_ff[3] <= '0;
         norm_ff  <= NORM_RESET;
      end else begin
         for (int i = 0; i < 4; i++) sq_ff[i] <= SQ_W'(rot_ff[i] * rot_ff[i]);
         norm_ff <= NORM_W'(sq_ff[0]) + NORM_W'(sq_ff[1])
                  + NORM_W'(sq_ff[2]) + NORM_W'(sq_ff[3]);
      end
   end

   // pipeline control: all stages move together
   logic           en;
   logic [LAT-1:0] vld_ff;

   assign en        = !vld_ff[LAT-1] || rsp.ready;
   assign req.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req.valid};
      end
   end

   // stage 1: rotor times input, all sixteen products
   logic signed [PROD_W-1:0] pa_ff [4][4];
   comp_type v [4];

   assign v[0] = req.in_w;
   assign v[1] = req.in_x;
   assign v[2] = req.in_y;
   assign v[3] = req.in_z;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
               pa_ff[i][j] <= rot_ff[i] * v[j];
      end
   end

   // stage 2: p = q * v
   logic signed [P_W-1:0] p_ff [4];

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff[0] <= P_W'(pa_ff[0][0]) - P_W'(pa_ff[1][1]) - P_W'(pa_ff[2][2])
                  - P_W'(pa_ff[3][3]);
         p_ff[1] <= P_W'(pa_ff[0][1]) + P_W'(pa_ff[1][0]) + P_W'(pa_ff[2][3])
                  - P_W'(pa_ff[3][2]);
         p_ff[2] <= P_W'(pa_ff[0][2]) + P_W'(pa_ff[2][0]) + P_W'(pa_ff[3][1])
                  - P_W'(pa_ff[1][3]);
         p_ff[3] <= P_W'(pa_ff[0][3]) + P_W'(pa_ff[1][2]) + P_W'(pa_ff[3][0])
                  - P_W'(pa_ff[2][1]);
      end
   end

   // stage 3: p times rotor; the conjugate signs are folded into stage 4
   logic signed [PROD2_W-1:0] pb_ff [4][4];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
               pb_ff[i][j] <= p_ff[i] * rot_ff[j];
      end
   end

   // stage 4: n = p * conj(q)
   logic signed [NUM_W-1:0] n_ff [4];

   always_ff @(posedge clock) begin
      if (en) begin
         n_ff[0] <= NUM_W'(pb_ff[0][0]) + NUM_W'(pb_ff[1][1]) + NUM_W'(pb_ff[2][2])
                  + NUM_W'(pb_ff[3][3]);
         n_ff[1] <= NUM_W'(pb_ff[1][0]) - NUM_W'(pb_ff[0][1]) - NUM_W'(pb_ff[2][3])
                  + NUM_W'(pb_ff[3][2]);
         n_ff[2] <= NUM_W'(pb_ff[2][0]) - NUM_W'(pb_ff[0][2]) - NUM_W'(pb_ff[3][1])
                  + NUM_W'(pb_ff[1][3]);
         n_ff[3] <= NUM_W'(pb_ff[3][0]) - NUM_W'(pb_ff[0][3]) - NUM_W'(pb_ff[1][2])
                  + NUM_W'(pb_ff[2][1]);
      end
   end

   // one divider lane per component
   comp_type quo [4];
   logic     clip [4];

   for (genvar k = 0; k < 4; k++) begin : g_lane
      qrot_div u_div (
         .clock (clock),
         .en    (en),
         .num   (n_ff[k]),
         .norm  (norm_ff),
         .quo   (quo[k]),
         .clip  (clip[k])
      );
   end

   // zero rotor forces zero outputs and masks the saturation flag
   logic zero_norm;

   assign zero_norm      = (norm_ff == '0);
   assign rsp.valid      = vld_ff[LAT-1];
   assign rsp.out_w      = zero_norm ? '0 : quo[0];
   assign rsp.out_x      = zero_norm ? '0 : quo[1];
   assign rsp.out_y      = zero_norm ? '0 : quo[2];
   assign rsp.out_z      = zero_norm ? '0 : quo[3];
   assign rsp.clipped    = !zero_norm && (clip[0] || clip[1] || clip[2] || clip[3]);
   assign rsp.zero_rotor = zero_norm;

   // a stalled pipe holds every valid bit
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline moved during a stall");

   // a rotor_x write lands in its register
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      (csr_wr && csr_idx == REG_ROTOR_X) |=> rot_ff[1] == $past(pwdata[COMP_W-1:0]))
      else $error("rotor write lost");

   // reset empties the pipe
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("result valid right after reset");

   // a zero rotor never reports saturation
   a_zero_noclip: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && zero_norm) |-> !rsp.clipped)
      else $error("clipped with zero rotor");

endmodule

`default_nettype wire

@@ rtl/qrot_div.sv @@
// qrot_div: pipelined signed-by-positive divider lane, truncating, saturating to 16 bits
// depends on qrot_pkg
`default_nettype none

module qrot_div
   import qrot_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    en,
   input  wire logic signed [NUM_W-1:0] num,
   input  wire logic [NORM_W-1:0]       norm,
   output logic signed [COMP_W-1:0]     quo,
   output logic                         clip
);

   localparam int STEPS = QUO_W / 2;

   logic [NUM_W-1:0] mag_ff [STEPS+1];
   logic [QUO_W-1:0] qt_ff  [STEPS+1];
   logic             neg_ff [STEPS+1];
   logic             ovf_ff [STEPS+1];
   logic signed [COMP_W-1:0] quo_ff, quo_in;
   logic             clip_ff, clip_in;

   // magnitude and overflow check against norm * 2^16
   always_ff @(posedge clock) begin
      if (en) begin
         mag_ff[0] <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
         neg_ff[0] <= num[NUM_W-1];
         ovf_ff[0] <= (num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num))
                      >= (NUM_W'(norm) << QUO_W);
         qt_ff[0]  <= '0;
      end
   end

   // two quotient bits a stage
   for (genvar j = 1; j <= STEPS; j++) begin : g_step
      localparam int BHI = QUO_W + 1 - 2 * j;
      localparam int BLO = QUO_W - 2 * j;
      logic [NUM_W-1:0] r1, r2, dhi, dlo;
      logic [QUO_W-1:0] q_in;
      always_comb begin
         dhi  = NUM_W'(norm) << BHI;
         dlo  = NUM_W'(norm) << BLO;
         q_in = qt_ff[j-1];
         r1   = mag_ff[j-1];
         if (r1 >= dhi) begin
            r1        = r1 - dhi;
            q_in[BHI] = 1'b1;
         end
         r2 = r1;
         if (r2 >= dlo) begin
            r2        = r2 - dlo;
            q_in[BLO] = 1'b1;
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            mag_ff[j] <= r2;
            qt_ff[j]  <= q_in;
            neg_ff[j] <= neg_ff[j-1];
            ovf_ff[j] <= ovf_ff[j-1];
         end
      end
   end

   // sign and saturation
   always_comb begin
      logic signed [COMP_W:0] nq;
      nq      = -$signed({1'b0, qt_ff[STEPS]});
      quo_in  = $signed(qt_ff[STEPS]);
      clip_in = 1'b0;
      if (!neg_ff[STEPS]) begin
         if (ovf_ff[STEPS] || qt_ff[STEPS][QUO_W-1]) begin
            quo_in  = 16'sh7fff;
            clip_in = 1'b1;
         end
      end else begin
         if (ovf_ff[STEPS] || qt_ff[STEPS] > 16'd32768) begin
            quo_in  = 16'sh8000;
            clip_in = 1'b1;
         end else begin
            quo_in  = nq[COMP_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         quo_ff  <= quo_in;
         clip_ff <= clip_in;
      end
   end

   assign quo  = quo_ff;
   assign clip = clip_ff;

endmodule

`default_nettype wire
